/* hdl/qalu_pkg.sv */
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types and constants for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qalu_pkg;

	// word width of every quaternion component and result value
	localparam int DATA_W = 32;

	// default number of fraction bits
	localparam int FRAC_BITS_DEF = 16;

	// operation codes carried on the slave tuser
	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_ADD  = 2'd1,
		OP_CONJ = 2'd2,
		OP_MAT  = 2'd3
	} op_t;

	// matrix row numbers
	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST  = 2'd3;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef word_t quat_t [4];

endpackage

/* hdl/quaternion_alu.sv */
// ----------------------------------------------------------------------------
// quaternion_alu
// Quaternion product, sum, conjugate and pivoted rotation matrix in signed
// fixed point, four register stages plus a row-serializing output register.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                         | tuser        | tlast
//  s_axis   | in  | a_w a_x a_y a_z b_w b_x b_y b_z | kind (2b)  | -
//  m_axis   | out | val_0 val_1 val_2 val_3       | row_index    | last
//
// a request passes through the operand register, product lanes, sums,
// pivot products and output register before its first result appears.
// product, sum and conjugate take one request per cycle back to back while
// no result waits; the matrix leaves as four rows, one per accepted beat, from the single output register.
// the whole pipeline advances together and holds when a result waits.
// arst_n clears the valid bits and the row index only; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_alu
	import qalu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [255:0] s_axis_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	input  logic [1:0]   s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // val_0, val_1, val_2, val_3
	output logic [1:0]   m_axis_tuser,  // row_index
	output logic         m_axis_tlast   // last
);

	localparam int TW = 2*DATA_W - FRAC_BITS;
	localparam int SW = TW + 3;
	localparam logic signed [SW-1:0] SMAX = {{(SW-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {{(SW-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [SW-1:0] ONE_S = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] ONE_W = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

	typedef logic signed [TW-1:0] trunc_t;

	function automatic word_t sat(input logic signed [SW-1:0] v);
		word_t r;
		if (v > SMAX) begin
			r = SMAX[DATA_W-1:0];
		end else if (v < SMIN) begin
			r = SMIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	logic adv;

	// stage 1: operand register
	logic  v_s1;
	op_t   op_s1;
	quat_t a_s1, b_s1;

	// stage 2: sixteen truncated product lanes
	logic   v_s2;
	op_t    op_s2;
	quat_t  a_s2, b_s2;
	trunc_t m_s2 [4][4];

	// stage 3: quaternion result and matrix entries
	logic  v_s3;
	op_t   op_s3;
	quat_t qv_s3, b_s3;
	word_t r_s3 [3][3];

	// stage 4: pivot products
	logic   v_s4;
	op_t    op_s4;
	quat_t  qv_s4, b_s4;
	word_t  r_s4 [3][3];
	trunc_t tp_s4 [3][3];

	// output register
	logic       out_v_q;
	logic       mat_q;
	logic [1:0] row_q;
	word_t      rows_q [4][4];

	logic last_now;
	assign last_now = !mat_q || (row_q == ROW_LAST);
	assign adv = !out_v_q || (m_axis_tready && last_now);
	assign s_axis_tready = adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_v_q <= 1'b0;
			row_q <= ROW_FIRST;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_v_q <= v_s4;
			row_q <= ROW_FIRST;
		end else if (m_axis_tready) begin
			row_q <= row_q + 2'd1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op_t'(s_axis_tuser);
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= s_axis_tdata[i*DATA_W +: DATA_W];
				b_s1[i] <= s_axis_tdata[(i+4)*DATA_W +: DATA_W];
			end
		end
	end

	// product lanes: a_i * b_j, or a_i * a_j for the matrix
	trunc_t m_c [4][4];
	always_comb begin
		logic signed [2*DATA_W-1:0] p;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p = a_s1[i] * ((op_s1 == OP_MAT) ? a_s1[j] : b_s1[j]);
				m_c[i][j] = p[2*DATA_W-1:FRAC_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			m_s2 <= m_c;
		end
	end

	// sums and saturation
	quat_t qv_c;
	word_t r_c [3][3];
	always_comb begin
		logic signed [SW-1:0] m [4][4];
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				m[i][j] = SW'(m_s2[i][j]);
			end
		end
		case (op_s2)
			OP_MUL: begin
				qv_c[0] = sat(m[0][0] - m[1][1] - m[2][2] - m[3][3]);
				qv_c[1] = sat(m[0][1] + m[1][0] + m[2][3] - m[3][2]);
				qv_c[2] = sat(m[0][2] - m[1][3] + m[2][0] + m[3][1]);
				qv_c[3] = sat(m[0][3] + m[1][2] - m[2][1] + m[3][0]);
			end
			OP_ADD: begin
				for (int i = 0; i < 4; i++) qv_c[i] = sat(SW'(a_s2[i]) + SW'(b_s2[i]));
			end
			default: begin
				qv_c[0] = a_s2[0];
				for (int i = 1; i < 4; i++) qv_c[i] = sat(-SW'(a_s2[i]));
			end
		endcase
		r_c[0][0] = sat(((m[0][0] + m[1][1]) <<< 1) - ONE_S);
		r_c[0][1] = sat((m[1][2] - m[0][3]) <<< 1);
		r_c[0][2] = sat((m[1][3] + m[0][2]) <<< 1);
		r_c[1][0] = sat((m[1][2] + m[0][3]) <<< 1);
		r_c[1][1] = sat(((m[0][0] + m[2][2]) <<< 1) - ONE_S);
		r_c[1][2] = sat((m[2][3] - m[0][1]) <<< 1);
		r_c[2][0] = sat((m[1][3] - m[0][2]) <<< 1);
		r_c[2][1] = sat((m[2][3] + m[0][1]) <<< 1);
		r_c[2][2] = sat(((m[0][0] + m[3][3]) <<< 1) - ONE_S);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3 <= op_s2;
			b_s3 <= b_s2;
			qv_s3 <= qv_c;
			r_s3 <= r_c;
		end
	end

	// pivot products p_k * r_kj
	trunc_t tp_c [3][3];
	always_comb begin
		logic signed [2*DATA_W-1:0] p;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				p = b_s3[k+1] * r_s3[k][j];
				tp_c[k][j] = p[2*DATA_W-1:FRAC_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4 <= op_s3;
			b_s4 <= b_s3;
			qv_s4 <= qv_s3;
			r_s4 <= r_s3;
			tp_s4 <= tp_c;
		end
	end

	// translation row
	word_t t_c [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (r_s4[2][j] == '0) begin
				t_c[j] = '0;
			end else begin
				t_c[j] = sat(SW'(b_s4[j+1]) - SW'(tp_s4[0][j]) - SW'(tp_s4[1][j])
					- SW'(tp_s4[2][j]));
			end
		end
	end

	// output register holds all rows of one request
	always_ff @(posedge clk) begin
		if (adv) begin
			mat_q <= (op_s4 == OP_MAT);
			if (op_s4 == OP_MAT) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) rows_q[i][j] <= r_s4[i][j];
					rows_q[i][3] <= '0;
				end
				for (int j = 0; j < 3; j++) rows_q[3][j] <= t_c[j];
				rows_q[3][3] <= ONE_W;
			end else begin
				rows_q[0] <= qv_s4;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser = row_q;
	assign m_axis_tlast = last_now;
	always_comb begin
		for (int j = 0; j < 4; j++) m_axis_tdata[j*DATA_W +: DATA_W] = rows_q[row_q][j];
	end

`ifndef NO_ASSERTIONS
	a_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !mat_q |-> row_q == ROW_FIRST)
		else $error("non-matrix result off row zero");
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && row_q == $past(row_q) + 2'd1)
		else $error("matrix row skipped or lost");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !(m_axis_tready && m_axis_tlast) |-> !s_axis_tready)
		else $error("request taken while output is busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s4) && $stable(v_s1))
		else $error("pipeline moved during stall");
`endif

endmodule
